// File: rtl/core/tdk_pkg.sv
// Time-of-day keeper package: register indexes, operation codes, day length
// and the reciprocal constants for the divide by 1000.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package tdk_pkg;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONSUMER_EN = 2'd0,
      CSR_PRODUCER_EN = 2'd1,
      CSR_INTERVAL    = 2'd2
   } csr_index_type;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [3:0]  STAMP_LEN = 4'd6;
   localparam logic [27:0] STAMP_MS_MASK = 28'hFFF_FFFF;
   localparam logic [28:0] DAY_MS = 29'd86_400_000;

   localparam logic [19:0] US_PER_MS = 20'd1000;
   localparam int unsigned RECIP_SHIFT = 30;
   localparam logic [20:0] RECIP_1000 = 21'd1_073_742;

   typedef struct packed {
      logic [9:0]  adv_ms;
      logic [9:0]  residual;
      logic [28:0] ms;
      logic [15:0] days;
   } advance_type;

endpackage

`default_nettype wire

// File: rtl/core/tdk_if.sv
// Channel interfaces of the time-of-day keeper: request, response and
// register write. Depends on tdk_pkg for the register port widths.
`timescale 1ns / 1ps
`default_nettype none

interface tdk_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [3:0]  frame_length;
   logic [31:0] frame_ms;
   logic [15:0] frame_days;
   logic        node_active;
   logic [19:0] elapsed_us;

   modport source (output valid, operation, frame_length, frame_ms, frame_days,
                   node_active, elapsed_us, input ready);
   modport sink (input valid, operation, frame_length, frame_ms, frame_days,
                 node_active, elapsed_us, output ready);
endinterface

interface tdk_rsp_if;
   logic        valid;
   logic        ready;
   logic        stamp_taken;
   logic [28:0] time_ms;
   logic [15:0] time_days;
   logic        send_frame;

   modport source (output valid, stamp_taken, time_ms, time_days, send_frame,
                   input ready);
   modport sink (input valid, stamp_taken, time_ms, time_days, send_frame,
                 output ready);
endinterface

interface tdk_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tdk_pkg::CSR_IDX_W-1:0]     index;
   logic [tdk_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tdk_advance.sv
// Clock advance for one tick: elapsed plus residual split into whole ms and
// a new residual by reciprocal multiply, then add with one midnight rollover.
// Depends on tdk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdk_advance (
   input  logic [28:0]               clock_ms,
   input  logic [15:0]               clock_days,
   input  logic [9:0]                residual,
   input  logic [19:0]               elapsed_us,
   output tdk_pkg::advance_type      result
);

   logic [19:0] total_us;
   logic [40:0] product;
   logic [9:0]  adv_ms;
   logic [19:0] whole_us;
   logic [19:0] rem_us;
   logic [28:0] ms_sum;

   always_comb begin
      total_us = elapsed_us + {10'b0, residual};
      product  = {21'b0, total_us} * {20'b0, tdk_pkg::RECIP_1000};
      adv_ms   = product[tdk_pkg::RECIP_SHIFT +: 10];
      whole_us = {10'b0, adv_ms} * tdk_pkg::US_PER_MS;
      rem_us   = total_us - whole_us;
      ms_sum   = clock_ms + {19'b0, adv_ms};

      result.adv_ms   = adv_ms;
      result.residual = rem_us[9:0];
      if (ms_sum >= tdk_pkg::DAY_MS) begin
         result.ms   = ms_sum - tdk_pkg::DAY_MS;
         result.days = clock_days + 16'd1;
      end else begin
         result.ms   = ms_sum;
         result.days = clock_days;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/time_of_day_keeper.sv
// Time-of-day keeper top level: input register, state update, result register
// and register file. Depends on tdk_pkg, tdk_if and tdk_advance.
//
//   channel   dir  handshake      contents
//   req_if    in   valid/ready    operation, frame fields, node_active, elapsed_us
//   rsp_if    out  valid/ready    stamp_taken, time_ms, time_days, send_frame
//   csr_if    in   valid/ready    register index, write data (always ready)
//
// One request per cycle sustained while rsp_if.ready holds high; a response passes
// through the input register, then the result register, before it is valid.
// The tick arithmetic (divide by 1000, add, rollover) is combinational logic.
// Reset clears all time state, the pending stamp and the registers.
// A stalled response holds the result register; the input register still
// takes one more request, then req_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_keeper #(
   parameter int unsigned MAX_ELAPSED_US = 1000000
) (
   input  logic        clock,
   input  logic        reset,
   tdk_req_if.sink     req_if,
   tdk_rsp_if.source   rsp_if,
   tdk_csr_if.sink     csr_if
);

   localparam logic [19:0] MaxElapsed = 20'(MAX_ELAPSED_US);

   logic        consumer_en_ff, producer_en_ff;
   logic [15:0] interval_ff;

   logic        in_valid_ff, in_valid_in;
   logic        in_op_ff;
   logic [3:0]  in_len_ff;
   logic [31:0] in_ms_ff;
   logic [15:0] in_days_ff;
   logic        in_active_ff;
   logic [19:0] in_elapsed_ff;

   logic [31:0] pending_ms_ff, pending_ms_in;
   logic [15:0] pending_days_ff, pending_days_in;
   logic        pending_flag_ff, pending_flag_in;
   logic [28:0] clock_ms_ff, clock_ms_in;
   logic [15:0] clock_days_ff, clock_days_in;
   logic [9:0]  residual_ff, residual_in;
   logic [16:0] prod_count_ff, prod_count_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_taken_ff, out_taken_in;
   logic        out_send_ff, out_send_in;

   logic        req_fire, proc_go;
   logic [19:0] elapsed_sat;
   logic [9:0]  adv_ms;
   tdk_pkg::advance_type adv;

   assign req_fire      = req_if.valid & req_if.ready;
   assign proc_go       = in_valid_ff & (~out_valid_ff | rsp_if.ready);
   assign req_if.ready  = ~in_valid_ff | proc_go;
   assign csr_if.ready  = 1'b1;
   assign in_valid_in   = req_fire | (in_valid_ff & ~proc_go);
   assign out_valid_in  = proc_go | (out_valid_ff & ~rsp_if.ready);
   assign elapsed_sat   = (in_elapsed_ff > MaxElapsed) ? MaxElapsed : in_elapsed_ff;

   tdk_advance u_advance (
      .clock_ms   (clock_ms_ff),
      .clock_days (clock_days_ff),
      .residual   (residual_ff),
      .elapsed_us (elapsed_sat),
      .result     (adv)
   );

   always_comb begin
      pending_ms_in   = pending_ms_ff;
      pending_days_in = pending_days_ff;
      pending_flag_in = pending_flag_ff;
      clock_ms_in     = clock_ms_ff;
      clock_days_in   = clock_days_ff;
      residual_in     = residual_ff;
      prod_count_in   = prod_count_ff;
      out_taken_in    = 1'b0;
      out_send_in     = 1'b0;
      adv_ms          = 10'd0;
      if (in_op_ff == tdk_pkg::OP_FRAME) begin
         if (in_len_ff == tdk_pkg::STAMP_LEN) begin
            pending_ms_in   = in_ms_ff;
            pending_days_in = in_days_ff;
            pending_flag_in = 1'b1;
         end
      end else begin
         pending_flag_in = 1'b0;
         if (in_active_ff && consumer_en_ff && pending_flag_ff) begin
            clock_ms_in   = {1'b0, pending_ms_ff[27:0] & tdk_pkg::STAMP_MS_MASK};
            clock_days_in = pending_days_ff;
            residual_in   = 10'd0;
            out_taken_in  = 1'b1;
         end else if (elapsed_sat != 20'd0) begin
            adv_ms        = adv.adv_ms;
            clock_ms_in   = adv.ms;
            clock_days_in = adv.days;
            residual_in   = adv.residual;
         end
         if (in_active_ff && producer_en_ff && (interval_ff != 16'd0)) begin
            if (prod_count_ff >= {1'b0, interval_ff}) begin
               prod_count_in = prod_count_ff - {1'b0, interval_ff};
               out_send_in   = 1'b1;
            end else begin
               prod_count_in = prod_count_ff + {7'b0, adv_ms};
            end
         end else begin
            prod_count_in = {1'b0, interval_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         consumer_en_ff <= 1'b0;
         producer_en_ff <= 1'b0;
         interval_ff    <= 16'd0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            tdk_pkg::CSR_CONSUMER_EN: consumer_en_ff <= csr_if.data[0];
            tdk_pkg::CSR_PRODUCER_EN: producer_en_ff <= csr_if.data[0];
            tdk_pkg::CSR_INTERVAL:    interval_ff    <= csr_if.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff      <= req_if.operation;
         in_len_ff     <= req_if.frame_length;
         in_ms_ff      <= req_if.frame_ms;
         in_days_ff    <= req_if.frame_days;
         in_active_ff  <= req_if.node_active;
         in_elapsed_ff <= req_if.elapsed_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ms_ff   <= 32'd0;
         pending_days_ff <= 16'd0;
         pending_flag_ff <= 1'b0;
         clock_ms_ff     <= 29'd0;
         clock_days_ff   <= 16'd0;
         residual_ff     <= 10'd0;
         prod_count_ff   <= 17'd0;
      end else if (proc_go) begin
         pending_ms_ff   <= pending_ms_in;
         pending_days_ff <= pending_days_in;
         pending_flag_ff <= pending_flag_in;
         clock_ms_ff     <= clock_ms_in;
         clock_days_ff   <= clock_days_in;
         residual_ff     <= residual_in;
         prod_count_ff   <= prod_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_go) begin
         out_taken_ff <= out_taken_in;
         out_send_ff  <= out_send_in;
      end
   end

   logic [28:0] out_ms_ff;
   logic [15:0] out_days_ff;

   always_ff @(posedge clock) begin
      if (proc_go) begin
         out_ms_ff   <= clock_ms_in;
         out_days_ff <= clock_days_in;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.stamp_taken = out_taken_ff;
   assign rsp_if.time_ms     = out_ms_ff;
   assign rsp_if.time_days   = out_days_ff;
   assign rsp_if.send_frame  = out_send_ff;

   a_residual_range: assert property (@(posedge clock) disable iff (reset)
      residual_ff < 10'd1000)
      else $error("residual out of range");

   a_tick_clears_pending: assert property (@(posedge clock) disable iff (reset)
      (proc_go && in_op_ff == tdk_pkg::OP_TICK) |=> !pending_flag_ff)
      else $error("pending stamp survived a tick");

   a_taken_clock: assert property (@(posedge clock) disable iff (reset)
      (proc_go && out_taken_in) |=> (out_taken_ff && residual_ff == 10'd0
                                     && clock_ms_ff[28] == 1'b0))
      else $error("stamp load did not reach the clock");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!out_valid_ff && !in_valid_ff))
      else $error("valid after reset");

endmodule

`default_nettype wire

// File: verif/time_of_day_keeper_tb.sv
// Self-checking testbench for time_of_day_keeper: random and directed requests with
// random gaps and response stalls, checked against a built-in time-of-day predictor.
// Depends on tdk_pkg, the tdk_if interfaces and the time_of_day_keeper RTL.
`timescale 1ns / 1ps

module time_of_day_keeper_tb;

   localparam int unsigned MAX_ELAPSED_US = 1000000;
   localparam int unsigned ITEMS_PER_PHASE = 225;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_LIMIT = 5000;
   localparam logic [tdk_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [3:0]  frame_length;
      logic [31:0] frame_ms;
      logic [15:0] frame_days;
      logic        node_active;
      logic [19:0] elapsed_us;
   } tod_request_type;

   typedef struct packed {
      logic        stamp_taken;
      logic [28:0] time_ms;
      logic [15:0] time_days;
      logic        send_frame;
   } tod_time_type;

   class tod_scoreboard;
      logic          consumer_en;
      logic          producer_en;
      logic [15:0]   interval_ms;
      logic [31:0]   stamp_ms;
      logic [15:0]   stamp_days;
      logic          stamp_pending;
      logic [28:0]   now_ms;
      logic [15:0]   now_days;
      logic [9:0]    carry_us;
      logic [16:0]   producer_ms;
      tod_time_type  expected_times[$];
      int unsigned   mismatches;
      int unsigned   responses;

      function new();
         consumer_en = 1'b0;
         producer_en = 1'b0;
         interval_ms = '0;
         stamp_ms = '0;
         stamp_days = '0;
         stamp_pending = 1'b0;
         now_ms = '0;
         now_days = '0;
         carry_us = '0;
         producer_ms = '0;
         mismatches = 0;
         responses = 0;
      endfunction

      task report(string what, logic [31:0] want, logic [31:0] got);
         if (mismatches < 40)
            $display("mismatch at response %0d: %s expected %0h got %0h",
                     responses, what, want, got);
         mismatches++;
      endtask

      function int unsigned pending();
         return expected_times.size();
      endfunction

      function void set_register(logic [tdk_pkg::CSR_IDX_W-1:0] index,
                                 logic [tdk_pkg::CSR_DATA_W-1:0] data);
         unique case (index)
            tdk_pkg::CSR_CONSUMER_EN: consumer_en = data[0];
            tdk_pkg::CSR_PRODUCER_EN: producer_en = data[0];
            tdk_pkg::CSR_INTERVAL:    interval_ms = data;
            default: ;
         endcase
      endfunction

      function void note_request(tod_request_type r);
         tod_time_type t;
         int unsigned  elapsed;
         int unsigned  total_us;
         int unsigned  advance_ms;
         t = '0;
         advance_ms = 0;
         if (r.operation == tdk_pkg::OP_FRAME) begin
            if (r.frame_length == tdk_pkg::STAMP_LEN) begin
               stamp_ms = r.frame_ms;
               stamp_days = r.frame_days;
               stamp_pending = 1'b1;
            end
         end else begin
            elapsed = r.elapsed_us;
            if (elapsed > MAX_ELAPSED_US) elapsed = MAX_ELAPSED_US;
            if (r.node_active && consumer_en) begin
               if (stamp_pending) begin
                  now_ms = {1'b0, stamp_ms[27:0] & tdk_pkg::STAMP_MS_MASK};
                  now_days = stamp_days;
                  carry_us = '0;
                  t.stamp_taken = 1'b1;
                  stamp_pending = 1'b0;
               end
            end else begin
               stamp_pending = 1'b0;
            end
            if (!t.stamp_taken && elapsed > 0) begin
               total_us = elapsed + carry_us;
               advance_ms = total_us / 1000;
               carry_us = 10'(total_us % 1000);
               now_ms = 29'(now_ms + advance_ms);
               if (now_ms >= tdk_pkg::DAY_MS) begin
                  now_ms = now_ms - tdk_pkg::DAY_MS;
                  now_days = now_days + 16'd1;
               end
            end
            if (r.node_active && producer_en && interval_ms != 0) begin
               if (producer_ms >= interval_ms) begin
                  producer_ms = producer_ms - interval_ms;
                  t.send_frame = 1'b1;
               end else begin
                  producer_ms = 17'(producer_ms + advance_ms);
               end
            end else begin
               producer_ms = interval_ms;
            end
         end
         t.time_ms = now_ms;
         t.time_days = now_days;
         expected_times.push_back(t);
      endfunction

      task check_response(tod_time_type got);
         tod_time_type want;
         if (expected_times.size() == 0) begin
            report("unexpected response, time_ms", '0, got.time_ms);
         end else begin
            want = expected_times.pop_front();
            if (got.stamp_taken !== want.stamp_taken)
               report("stamp_taken", want.stamp_taken, got.stamp_taken);
            if (got.time_ms !== want.time_ms)
               report("time_ms", want.time_ms, got.time_ms);
            if (got.time_days !== want.time_days)
               report("time_days", want.time_days, got.time_days);
            if (got.send_frame !== want.send_frame)
               report("send_frame", want.send_frame, got.send_frame);
         end
         responses++;
      endtask
   endclass

   logic clock;
   logic reset;
   logic calm;
   int unsigned stall_left;
   int unsigned calm_count;
   int unsigned cycle_count;
   tod_scoreboard sb;

   tdk_req_if req_bus();
   tdk_rsp_if rsp_bus();
   tdk_csr_if csr_bus();

   time_of_day_keeper #(.MAX_ELAPSED_US(MAX_ELAPSED_US)) uut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   always #5 clock = ~clock;

   function automatic int unsigned idle_length();
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // sample accepted requests, register writes and responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            sb.note_request({req_bus.operation, req_bus.frame_length, req_bus.frame_ms,
                             req_bus.frame_days, req_bus.node_active, req_bus.elapsed_us});
         if (csr_bus.valid && csr_bus.ready)
            sb.set_register(csr_bus.index, csr_bus.data);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response({rsp_bus.stamp_taken, rsp_bus.time_ms, rsp_bus.time_days,
                               rsp_bus.send_frame});
      end
      calm_count <= calm_count + 1;
      if (calm_count % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
   end

   // stall the response side
   always @(negedge clock) begin
      if (stall_left > 0) stall_left--;
      else if (!calm && $urandom_range(0, 7) == 0) stall_left = idle_length();
      rsp_bus.ready <= (stall_left == 0);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic tod_request_type noise_request();
      tod_request_type r;
      r.operation = 1'($urandom_range(0, 1));
      r.frame_length = 4'($urandom_range(0, 15));
      r.frame_ms = $urandom();
      r.frame_days = 16'($urandom_range(0, 16'hFFFF));
      r.node_active = 1'($urandom_range(0, 1));
      r.elapsed_us = 20'($urandom_range(0, 20'hFFFFF));
      return r;
   endfunction

   function automatic tod_request_type frame_request(logic [3:0] len, logic [31:0] ms,
                                                     logic [15:0] days);
      tod_request_type r;
      r = noise_request();
      r.operation = tdk_pkg::OP_FRAME;
      r.frame_length = len;
      r.frame_ms = ms;
      r.frame_days = days;
      return r;
   endfunction

   function automatic tod_request_type tick_request(logic active, logic [19:0] elapsed);
      tod_request_type r;
      r = noise_request();
      r.operation = tdk_pkg::OP_TICK;
      r.node_active = active;
      r.elapsed_us = elapsed;
      return r;
   endfunction

   function automatic tod_request_type random_request();
      tod_request_type r;
      int unsigned pick;
      r = noise_request();
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
         r.operation = tdk_pkg::OP_FRAME;
         r.frame_length = tdk_pkg::STAMP_LEN;
         case ($urandom_range(0, 3))
            0: r.frame_ms = tdk_pkg::DAY_MS - $urandom_range(1, 5000);
            1: r.frame_ms = $urandom_range(0, tdk_pkg::DAY_MS - 1);
            2: r.frame_ms = $urandom();
            default: r.frame_ms = $urandom_range(0, 100000);
         endcase
         if ($urandom_range(0, 3) == 0) r.frame_days = 16'hFFFF - 16'($urandom_range(0, 2));
      end else if (pick < 20) begin
         r.operation = tdk_pkg::OP_FRAME;
      end else begin
         r.operation = tdk_pkg::OP_TICK;
         r.node_active = ($urandom_range(0, 9) != 0);
         case ($urandom_range(0, 19)) inside
            0: r.elapsed_us = '0;
            1, 2: r.elapsed_us = 20'(MAX_ELAPSED_US);
            3: r.elapsed_us = 20'($urandom_range(0, 20'hFFFFF));
            [4:7]: r.elapsed_us = 20'($urandom_range(1000, 200000));
            default: r.elapsed_us = 20'($urandom_range(1, 3000));
         endcase
      end
      return r;
   endfunction

   // entered and left at a falling edge
   task automatic push_request(tod_request_type r);
      int unsigned gap;
      gap = calm ? 0 : ($urandom_range(0, 1) == 0 ? 0 : idle_length());
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.operation = r.operation;
      req_bus.frame_length = r.frame_length;
      req_bus.frame_ms = r.frame_ms;
      req_bus.frame_days = r.frame_days;
      req_bus.node_active = r.node_active;
      req_bus.elapsed_us = r.elapsed_us;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(logic [tdk_pkg::CSR_IDX_W-1:0] index,
                                 logic [tdk_pkg::CSR_DATA_W-1:0] data);
      csr_bus.index = index;
      csr_bus.data = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic configure(logic consumer, logic producer, logic [15:0] interval);
      write_register(tdk_pkg::CSR_CONSUMER_EN, {15'($urandom()), consumer});
      write_register(tdk_pkg::CSR_PRODUCER_EN, {15'($urandom()), producer});
      write_register(tdk_pkg::CSR_INTERVAL, interval);
   endtask

   task automatic drain();
      int unsigned waited;
      req_bus.valid = 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (6) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      calm = 1'b0;
      stall_left = 0;
      calm_count = 0;
      sb = new();
      req_bus.valid = 1'b0;
      req_bus.operation = tdk_pkg::OP_FRAME;
      req_bus.frame_length = '0;
      req_bus.frame_ms = '0;
      req_bus.frame_days = '0;
      req_bus.node_active = 1'b0;
      req_bus.elapsed_us = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = tdk_pkg::CSR_CONSUMER_EN;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(negedge clock);

      configure(1'b1, 1'b1, 16'd1);
      write_register(CSR_UNUSED, 16'hFFFF);
      push_request(tick_request(1'b1, 20'd0));
      push_request(tick_request(1'b1, 20'd999));
      push_request(tick_request(1'b1, 20'd1));
      push_request(tick_request(1'b1, 20'hFFFFF));
      push_request(frame_request(4'd5, 32'h1234_5678, 16'h00FF));
      push_request(frame_request(tdk_pkg::STAMP_LEN, tdk_pkg::DAY_MS - 1, 16'hFFFF));
      push_request(tick_request(1'b1, 20'(MAX_ELAPSED_US)));
      push_request(tick_request(1'b1, 20'd2000));
      push_request(frame_request(tdk_pkg::STAMP_LEN, 32'hFFFF_FFFF, 16'h0000));
      push_request(tick_request(1'b1, 20'd0));
      push_request(tick_request(1'b1, 20'(MAX_ELAPSED_US)));
      push_request(tick_request(1'b1, 20'(MAX_ELAPSED_US)));
      push_request(frame_request(tdk_pkg::STAMP_LEN, 32'd0, 16'd0));
      push_request(tick_request(1'b0, 20'd1500));
      push_request(tick_request(1'b1, 20'd1500));
      push_request(frame_request(4'd15, 32'hFFFF_FFFF, 16'hFFFF));
      push_request(frame_request(4'd8, 32'd0, 16'd0));
      push_request(frame_request(4'd0, 32'hA5A5_A5A5, 16'h5A5A));
      push_request(frame_request(tdk_pkg::STAMP_LEN, 32'd12345, 16'd1));
      push_request(tick_request(1'b1, 20'd500));
      drain();

      configure(1'b0, 1'b0, 16'd0);
      push_request(frame_request(tdk_pkg::STAMP_LEN, 32'd777, 16'd3));
      push_request(tick_request(1'b1, 20'd1000));
      drain();
      configure(1'b1, 1'b1, 16'hFFFF);
      push_request(tick_request(1'b1, 20'd1000));
      push_request(tick_request(1'b1, 20'd1000));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(1'b1, 1'b1, 16'd5);
            1: configure(1'b0, 1'b1, 16'd250);
            2: configure(1'b1, 1'b0, 16'd1000);
            3: configure(1'b1, 1'b1, 16'hFFFF);
            4: configure(1'b0, 1'b0, 16'd0);
            5: configure(1'b1, 1'b1, 16'd1);
            6: configure(1'b1, 1'b1, 16'($urandom_range(2, 3000)));
            default: configure(1'b0, 1'b1, 16'($urandom_range(1, 20)));
         endcase
         repeat (ITEMS_PER_PHASE) push_request(random_request());
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report("responses missing, count", 0, sb.pending());
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
rtl/core/tdk_pkg.sv
rtl/core/tdk_if.sv
rtl/core/tdk_advance.sv
rtl/core/time_of_day_keeper.sv
verif/time_of_day_keeper_tb.sv
